[sv/stp_pkg.sv]
package stp_pkg;

    // coil drive levels
    localparam logic HIGH = 1'b1;
    localparam logic LOW  = 1'b0;

    localparam int POS_W   = 16;
    localparam int DELAY_W = 16;
    localparam int COIL_W  = 4;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_TICK = 2'd0;
    localparam t_func FUNC_MOVE = 2'd1;
    localparam t_func FUNC_HOME = 2'd2;
    localparam t_func FUNC_IDLE = 2'd3;

    // full-step patterns, bit3 A, bit2 B, bit1 C, bit0 D
    function automatic logic [COIL_W-1:0] f_coil_pattern(input logic ccw,
                                                         input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        case ({ccw, phase})
            3'b000:  pat = {LOW,  HIGH, HIGH, LOW};
            3'b001:  pat = {LOW,  HIGH, LOW,  HIGH};
            3'b010:  pat = {HIGH, LOW,  LOW,  HIGH};
            3'b011:  pat = {HIGH, LOW,  HIGH, LOW};
            3'b100:  pat = {HIGH, LOW,  HIGH, LOW};
            3'b101:  pat = {HIGH, LOW,  LOW,  HIGH};
            3'b110:  pat = {LOW,  HIGH, LOW,  HIGH};
            3'b111:  pat = {LOW,  HIGH, HIGH, LOW};
            default: pat = {LOW,  LOW,  LOW,  LOW};
        endcase
        return pat;
    endfunction

endpackage

[sv/stepper_move_to_sequencer.sv]
// a request's result is registered and shows in the cycle after the request is accepted
// throughput: one request per cycle while the result side is ready; the motor state and the result register are
//   updated together in one pass of shallow logic (16-bit compare and increment)
// reset: synchronous active-low i_rst_n clears position, target, move state and coils,
//   empties the result register and sets step_delay to 10
module stepper_move_to_sequencer (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: step_delay
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_wdata,
    // request side
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [15:0]            i_s_tdata,   // [15:0] target_position
    input  stp_pkg::t_func         i_s_tuser,   // [1:0] func
    // result side
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [23:0]            o_m_tdata    // [3:0] coils, [19:4] position,
                                                // [20] busy_res, [23:21] zero
);
    import stp_pkg::*;

    // configuration register
    logic [DELAY_W-1:0] r_step_delay;

    // motor state; the result fields are read straight from it
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [POS_W-1:0]   r_target, n_target;
    logic               r_moving, n_moving;
    logic               r_ccw,    n_ccw;
    logic [1:0]         r_phase,  n_phase;
    logic [DELAY_W-1:0] r_hold,   n_hold;
    logic [COIL_W-1:0]  r_coil,   n_coil;
    logic               r_out_valid;

    logic               accept;
    logic [DELAY_W-1:0] limit;
    logic               cycle_start;
    logic               past_target;
    logic [DELAY_W:0]   hold_inc;

    // a new request goes in whenever the result register is empty or being drained,
    // so the state only moves while the previous result has left
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    // a zero delay behaves as one tick per pattern
    assign limit       = (r_step_delay == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : r_step_delay;
    assign cycle_start = (r_phase == 2'd0) && (r_hold == '0);
    // ccw runs while pos >= target, cw while pos <= target
    assign past_target = r_ccw ? ($signed(r_pos) < $signed(r_target))
                               : ($signed(r_pos) > $signed(r_target));
    assign hold_inc    = {1'b0, r_hold} + {{DELAY_W{1'b0}}, 1'b1};

    always_comb begin
        n_pos    = r_pos;
        n_target = r_target;
        n_moving = r_moving;
        n_ccw    = r_ccw;
        n_phase  = r_phase;
        n_hold   = r_hold;
        n_coil   = r_coil;
        case (i_s_tuser)
            FUNC_TICK: begin
                if (r_moving) begin
                    if (cycle_start && past_target) begin
                        // move done, coils stay energized on the last pattern
                        n_moving = 1'b0;
                    end else begin
                        if (cycle_start) begin
                            n_pos = r_ccw ? (r_pos - 1'b1) : (r_pos + 1'b1);
                        end
                        n_coil = f_coil_pattern(r_ccw, r_phase);
                        if (hold_inc >= {1'b0, limit}) begin
                            n_hold  = '0;
                            n_phase = r_phase + 2'd1;
                        end else begin
                            n_hold = hold_inc[DELAY_W-1:0];
                        end
                    end
                end
            end
            FUNC_MOVE: begin
                // direction is fixed once here; a running move restarts
                n_target = i_s_tdata;
                n_ccw    = $signed(r_pos) >= $signed(i_s_tdata);
                n_moving = 1'b1;
                n_phase  = 2'd0;
                n_hold   = '0;
            end
            FUNC_HOME: begin
                n_pos = '0;
            end
            FUNC_IDLE: begin
                n_coil   = '0;
                n_moving = 1'b0;
                n_phase  = 2'd0;
                n_hold   = '0;
            end
            default: begin
                n_coil = r_coil;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_delay <= DELAY_RESET;
            r_pos        <= '0;
            r_target     <= '0;
            r_moving     <= 1'b0;
            r_ccw        <= 1'b0;
            r_phase      <= 2'd0;
            r_hold       <= '0;
            r_coil       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step_delay <= i_cfg_wdata;
            end
            if (accept) begin
                r_pos    <= n_pos;
                r_target <= n_target;
                r_moving <= n_moving;
                r_ccw    <= n_ccw;
                r_phase  <= n_phase;
                r_hold   <= n_hold;
                r_coil   <= n_coil;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_moving, r_pos, r_coil};

    // idle request always leaves coils off and the move stopped
    a_idle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_s_tuser == FUNC_IDLE) |=> r_out_valid && (r_coil == '0) && !r_moving)
        else $error("idle request did not de-energize coils");

    // a move request takes no step of its own
    a_move_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_s_tuser == FUNC_MOVE) |=> r_moving && (r_pos == $past(r_pos)))
        else $error("move request changed position or did not start");

    // home request zeroes the position
    a_home_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_s_tuser == FUNC_HOME) |=> (r_pos == '0))
        else $error("home request did not zero position");

    // with no move running the step cycle sits at its start
    a_stopped_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_moving |-> (r_phase == 2'd0) && (r_hold == '0))
        else $error("step cycle not at start while stopped");

    // state never moves while a result waits
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> $stable(r_pos) && $stable(r_coil) && $stable(r_moving))
        else $error("state changed under a stalled result");

endmodule

[dv/stepper_move_to_sequencer_tb.sv]
module stepper_move_to_sequencer_tb;
    import stp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    // coil sequences indexed by phase, phase 0 in the low nibble
    localparam logic [15:0] CW_SEQ  = {4'b1010, 4'b1001, 4'b0101, 4'b0110};
    localparam logic [15:0] CCW_SEQ = {4'b0110, 4'b0101, 4'b1001, 4'b1010};

    // same layout as o_m_tdata[20:0]
    typedef struct packed {
        logic               busy;
        logic signed [15:0] position;
        logic [3:0]         coils;
    } t_motor_out;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;   // [15:0] target_position
    t_func       i_s_tuser   = FUNC_TICK;   // [1:0] func
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;          // [3:0] coils, [19:4] position, [20] busy_res

    // motor model state, mirrors the block after reset
    logic [15:0]        delay_m  = DELAY_RESET;
    logic signed [15:0] pos_m    = '0;
    logic signed [15:0] tgt_m    = '0;
    logic               moving_m = 1'b0;
    logic               ccw_m    = 1'b0;
    logic [1:0]         phase_m  = '0;
    logic [15:0]        hold_m   = '0;
    logic [3:0]         coil_m   = '0;

    t_motor_out motor_out_q[$];
    t_motor_out got_out;
    t_motor_out want_out;

    int  err_count        = 0;
    int  cycle_count      = 0;
    int  requests_sent    = 0;
    int  sink_hold_cycles = 0;
    bit  src_gaps_on      = 1'b0;
    bit  sink_gaps_on     = 1'b0;

    stepper_move_to_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result sink: random stall bursts, or one long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                i_m_tready = 1'b0;
                repeat (sink_hold_cycles) @(negedge i_clk);
                sink_hold_cycles = 0;
                i_m_tready = 1'b1;
            end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_m_tready = 1'b1;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // compare every accepted result against the oldest predicted one
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_out = o_m_tdata[20:0];
            if (motor_out_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_m_tdata);
            end else begin
                want_out = motor_out_q.pop_front();
                if (got_out.coils !== want_out.coils) begin
                    err_count++;
                    $display("%0t: coils expected %b actual %b",
                             $time, want_out.coils, got_out.coils);
                end
                if (got_out.position !== want_out.position) begin
                    err_count++;
                    $display("%0t: position expected %0d actual %0d",
                             $time, want_out.position, got_out.position);
                end
                if (got_out.busy !== want_out.busy) begin
                    err_count++;
                    $display("%0t: busy expected %b actual %b",
                             $time, want_out.busy, got_out.busy);
                end
                if (o_m_tdata[23:21] !== 3'b000) begin
                    err_count++;
                    $display("%0t: pad bits expected 000 actual %b",
                             $time, o_m_tdata[23:21]);
                end
            end
        end
    end

    // offer one request, wait for it to be taken, then update the motor model
    task automatic send_request(input t_func fn, input logic [15:0] tgt);
        int hold_lim;
        @(negedge i_clk);
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = fn;
        i_s_tdata  = tgt;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        requests_sent++;

        hold_lim = (delay_m == 16'd0) ? 1 : int'(delay_m);
        case (fn)
            FUNC_TICK: begin
                if (moving_m) begin
                    // a new cycle first checks whether the move is past its target
                    if (phase_m == 2'd0 && hold_m == 16'd0 &&
                        (ccw_m ? (pos_m < tgt_m) : (pos_m > tgt_m))) begin
                        moving_m = 1'b0;
                    end else begin
                        if (phase_m == 2'd0 && hold_m == 16'd0) begin
                            pos_m = ccw_m ? pos_m - 16'sd1 : pos_m + 16'sd1;
                        end
                        coil_m = ccw_m ? CCW_SEQ[{phase_m, 2'b00} +: 4]
                                       : CW_SEQ[{phase_m, 2'b00} +: 4];
                        if (int'(hold_m) + 1 >= hold_lim) begin
                            hold_m  = '0;
                            phase_m = phase_m + 2'd1;
                        end else begin
                            hold_m = hold_m + 16'd1;
                        end
                    end
                end
            end
            FUNC_MOVE: begin
                tgt_m    = tgt;
                ccw_m    = (pos_m >= tgt_m);
                moving_m = 1'b1;
                phase_m  = '0;
                hold_m   = '0;
            end
            FUNC_HOME: begin
                pos_m = '0;
            end
            FUNC_IDLE: begin
                coil_m   = '0;
                moving_m = 1'b0;
                phase_m  = '0;
                hold_m   = '0;
            end
            default: ;
        endcase
        motor_out_q.push_back({moving_m, pos_m, coil_m});
    endtask

    // stop offering and let every outstanding result come back
    task automatic settle_block();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (motor_out_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_step_delay(input logic [15:0] value);
        settle_block();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        delay_m     = value;
    endtask

    // tick until the model says the move is over, optionally with interruptions
    task automatic tick_while_moving(input int cap, input bit interrupt);
        int steps;
        int choice;
        steps = 0;
        while (moving_m && steps < cap) begin
            choice = interrupt ? $urandom_range(0, 63) : 63;
            if (choice == 0) begin
                send_request(FUNC_HOME, 16'($urandom));
            end else if (choice == 1) begin
                send_request(FUNC_IDLE, 16'($urandom));
            end else if (choice == 2) begin
                send_request(FUNC_MOVE, pos_m + 16'($urandom_range(0, 12)) - 16'd6);
            end else begin
                send_request(FUNC_TICK, 16'($urandom));
            end
            steps++;
        end
    endtask

    task automatic test_after_reset();
        // idle tick shows reset state, home on a stopped motor
        send_request(FUNC_TICK, 16'hFFFF);
        send_request(FUNC_HOME, 16'h0000);
    endtask

    task automatic test_ccw_move_with_home();
        // zero delay behaves as one tick per pattern
        write_step_delay(16'd0);
        // target equal to position goes counterclockwise
        send_request(FUNC_MOVE, 16'h0000);
        repeat (2) send_request(FUNC_TICK, 16'($urandom));
        // home in the middle of a cycle, move keeps going
        send_request(FUNC_HOME, 16'($urandom));
        tick_while_moving(40, 1'b0);
        // tick after the move ended, coils stay energized
        send_request(FUNC_TICK, 16'($urandom));
    endtask

    task automatic test_cw_move();
        send_request(FUNC_MOVE, 16'h0000);
        tick_while_moving(40, 1'b0);
    endtask

    task automatic test_unreachable_targets();
        // clockwise to the top and counterclockwise to the bottom never end
        send_request(FUNC_MOVE, 16'h7FFF);
        repeat (2) send_request(FUNC_TICK, 16'($urandom));
        send_request(FUNC_MOVE, 16'h8000);
        repeat (2) send_request(FUNC_TICK, 16'($urandom));
        send_request(FUNC_IDLE, 16'hFFFF);
        send_request(FUNC_TICK, 16'($urandom));
    endtask

    task automatic test_hold_extremes();
        write_step_delay(16'hFFFF);
        send_request(FUNC_MOVE, 16'h0001);
        repeat (4) send_request(FUNC_TICK, 16'($urandom));
        // shorter delay while a pattern is already held past it
        write_step_delay(16'd1);
        repeat (5) send_request(FUNC_TICK, 16'($urandom));
        send_request(FUNC_IDLE, 16'($urandom));
    endtask

    task automatic test_random_traffic(input int n_items);
        int goal;
        int choice;
        goal = requests_sent + n_items;
        while (requests_sent < goal) begin
            choice = $urandom_range(0, 19);
            if (choice == 0) begin
                if ($urandom_range(0, 7) == 0) begin
                    write_step_delay(16'($urandom));
                end else begin
                    write_step_delay(16'($urandom_range(0, 3)));
                end
            end else if (choice < 16) begin
                // well-formed move: near target mostly, far target now and then
                if ($urandom_range(0, 7) == 0) begin
                    send_request(FUNC_MOVE, 16'($urandom));
                end else begin
                    send_request(FUNC_MOVE, pos_m + 16'($urandom_range(0, 18)) - 16'd9);
                end
                tick_while_moving(150, 1'b1);
                repeat ($urandom_range(0, 2)) send_request(FUNC_TICK, 16'($urandom));
                if ($urandom_range(0, 3) == 0) begin
                    send_request(FUNC_IDLE, 16'($urandom));
                end
            end else begin
                // noise: any request with any payload
                repeat ($urandom_range(1, 6)) begin
                    send_request(t_func'($urandom_range(0, 3)), 16'($urandom));
                end
            end
        end
    endtask

    task automatic test_stalled_sink();
        // sink holds off long enough for the request side to back up
        sink_hold_cycles = 250;
        test_random_traffic(40);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        test_after_reset();
        test_ccw_move_with_home();
        test_cw_move();
        test_unreachable_targets();
        test_hold_extremes();

        test_random_traffic(700);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        test_random_traffic(300);
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        test_stalled_sink();
        test_random_traffic(500);
        // final stretch at full rate
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        test_random_traffic(300);

        settle_block();
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
